FILE: rtl/lsp_pkg.sv
`default_nettype none

package lsp_pkg;

  // Storage depth, in cells
  localparam int DEPTH  = 16;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int DATA_W = 32;
  localparam int MODE_W = 3;
  localparam int POS_W  = 5;
  localparam int CAP_W  = 5;
  localparam int ST_W   = 2;
  // Compare width wide enough for count, capacity and position alike
  localparam int CMP_W  = (CNT_W > CAP_W) ? CNT_W : CAP_W;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

  localparam logic [MODE_W-1:0] MODE_PUSH   = 3'd0;
  localparam logic [MODE_W-1:0] MODE_POP    = 3'd1;
  localparam logic [MODE_W-1:0] MODE_PEEK   = 3'd2;
  localparam logic [MODE_W-1:0] MODE_TOP    = 3'd3;
  localparam logic [MODE_W-1:0] MODE_BOTTOM = 3'd4;

  localparam logic [ST_W-1:0] ST_OK        = 2'd0;
  localparam logic [ST_W-1:0] ST_OVERFLOW  = 2'd1;
  localparam logic [ST_W-1:0] ST_UNDERFLOW = 2'd2;
  localparam logic [ST_W-1:0] ST_BADPOS    = 2'd3;

  // Shift command broadcast to every cell
  typedef struct packed {
    logic push;
    logic pop;
  } shift_ctl_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] data;
    logic [ST_W-1:0]          status;
    logic                     is_empty;
    logic                     is_full;
  } result_t;

endpackage

`default_nettype wire

FILE: rtl/lsp_cell.sv
`default_nettype none

module lsp_cell
  import lsp_pkg::*;
(
  input  wire logic                     clk,
  input  wire shift_ctl_t               ctl,
  input  wire logic signed [DATA_W-1:0] from_above,
  input  wire logic signed [DATA_W-1:0] from_below,
  output logic signed [DATA_W-1:0]      q
);

  logic signed [DATA_W-1:0] word_r;
  logic signed [DATA_W-1:0] word_nxt;

  // push: take the neighbor nearer the top; pop: take the one below
  always_comb begin
    word_nxt = word_r;
    if (ctl.push) begin
      word_nxt = from_above;
    end else if (ctl.pop) begin
      word_nxt = from_below;
    end
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
  end

  assign q = word_r;

endmodule

`default_nettype wire

FILE: rtl/lsp_ctrl.sv
`default_nettype none

module lsp_ctrl
  import lsp_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     fire,
  input  wire logic [MODE_W-1:0]        mode,
  input  wire logic [POS_W-1:0]         position,
  input  wire logic [CAP_W-1:0]         cap,
  input  wire logic signed [DATA_W-1:0] top_word,
  input  wire logic signed [DATA_W-1:0] sel_word,
  output shift_ctl_t                    ctl,
  output logic [IDX_W-1:0]              rd_idx,
  output result_t                       res
);

  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;
  logic [CNT_W-1:0] count_upd;
  logic [CMP_W-1:0] cnt_ext;
  logic [CMP_W-1:0] cap_ext;
  logic [CMP_W-1:0] eff_cap;
  logic [CMP_W-1:0] pos_ext;
  logic [CMP_W-1:0] peek_off;
  logic [CMP_W-1:0] bot_off;
  logic             empty;
  logic             full;
  shift_ctl_t       op;

  assign cnt_ext  = CMP_W'(count_r);
  assign cap_ext  = CMP_W'(cap);
  assign pos_ext  = CMP_W'(position);
  assign peek_off = pos_ext - CMP_W'(1);
  assign bot_off  = cnt_ext - CMP_W'(1);

  // capacity clamped to 1..DEPTH
  always_comb begin
    eff_cap = cap_ext;
    if (cap_ext == '0) begin
      eff_cap = CMP_W'(1);
    end else if (cap_ext > CMP_W'(DEPTH)) begin
      eff_cap = CMP_W'(DEPTH);
    end
  end

  assign empty = (count_r == '0);
  assign full  = (cnt_ext >= eff_cap);

  always_comb begin
    op         = '0;
    count_upd  = count_r;
    rd_idx     = peek_off[IDX_W-1:0];
    res.data   = '0;
    res.status = ST_OK;
    unique case (mode)
      MODE_PUSH: begin
        if (full) begin
          res.status = ST_OVERFLOW;
        end else begin
          op.push   = 1'b1;
          count_upd = count_r + CNT_W'(1);
        end
      end
      MODE_POP: begin
        if (empty) begin
          res.status = ST_UNDERFLOW;
          res.data   = '1;
        end else begin
          op.pop    = 1'b1;
          count_upd = count_r - CNT_W'(1);
          res.data  = top_word;
        end
      end
      MODE_PEEK: begin
        if (position == '0 || pos_ext > cnt_ext) begin
          res.status = ST_BADPOS;
          res.data   = '1;
        end else begin
          res.data = sel_word;
        end
      end
      MODE_TOP: begin
        if (empty) begin
          res.status = ST_UNDERFLOW;
          res.data   = '1;
        end else begin
          res.data = top_word;
        end
      end
      MODE_BOTTOM: begin
        rd_idx = bot_off[IDX_W-1:0];
        if (empty) begin
          res.status = ST_UNDERFLOW;
          res.data   = '1;
        end else begin
          res.data = sel_word;
        end
      end
      default: begin
      end
    endcase
    // flags as they stand after the request
    res.is_empty = (count_upd == '0);
    res.is_full  = (CMP_W'(count_upd) >= eff_cap);
  end

  assign ctl       = fire ? op : '0;
  assign count_nxt = fire ? count_upd : count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/lifo_stack_with_peek.sv
`default_nettype none

// LIFO stack of signed 32-bit words, DEPTH cells (16 by default), with the
// fill limit set by the capacity register (clamped to 1..DEPTH, reset 16;
// write it only while no request is outstanding). Requests are push, pop,
// peek by position from the top (1 = top), read top and read bottom; each
// returns one result with data, status (ok, overflow, underflow, invalid
// position) and the empty/full flags after the request. A push onto a full
// stack is dropped; failed pop, peek, top or bottom reads give -1. The words
// live in a row of cells with the top in cell 0: a push shifts every cell one
// place down and a pop one place up, so the top is always at a fixed spot and
// a peek or bottom read is a single index into the row. The block takes one
// request per cycle while in_stall is low; each result is registered in an
// output register backed by one skid register, so a request is still taken
// while one result waits. in_stall rises only when both are full.
module lifo_stack_with_peek
  import lsp_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  // configuration
  input  wire logic                     cfg_we,
  input  wire logic [CAP_W-1:0]         cfg_wdata,
  // request channel
  input  wire logic                     in_valid,
  output logic                          in_stall,
  input  wire logic [MODE_W-1:0]        in_mode,
  input  wire logic signed [DATA_W-1:0] in_value,
  input  wire logic [POS_W-1:0]         in_position,
  // result channel
  output logic                          out_valid,
  input  wire logic                     out_stall,
  output logic signed [DATA_W-1:0]      out_data,
  output logic [ST_W-1:0]               out_status,
  output logic                          out_is_empty,
  output logic                          out_is_full
);

  logic [CAP_W-1:0]         cap_r;
  logic signed [DATA_W-1:0] cell_q [DEPTH];
  logic signed [DATA_W-1:0] sel_word;
  logic [IDX_W-1:0]         rd_idx;
  shift_ctl_t               ctl;
  result_t                  res;
  logic                     in_fire;
  logic                     out_take;

  result_t out_r;
  result_t out_nxt;
  result_t skid_r;
  result_t skid_nxt;
  logic    out_valid_r;
  logic    out_valid_nxt;
  logic    skid_valid_r;
  logic    skid_valid_nxt;

  // capacity register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_RESET;
    end else if (cfg_we) begin
      cap_r <= cfg_wdata;
    end
  end

  assign in_stall = skid_valid_r;
  assign in_fire  = in_valid & ~skid_valid_r;
  assign out_take = out_valid_r & ~out_stall;

  // row of storage cells, top at index 0
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [DATA_W-1:0] above;
    logic signed [DATA_W-1:0] below;
    if (i == 0) begin : g_head
      assign above = in_value;
    end else begin : g_mid
      assign above = cell_q[i-1];
    end
    if (i == DEPTH - 1) begin : g_tail
      assign below = '0;
    end else begin : g_body
      assign below = cell_q[i+1];
    end
    lsp_cell u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .from_above (above),
      .from_below (below),
      .q          (cell_q[i])
    );
  end

  // peek / bottom word: one indexed read of the row
  assign sel_word = cell_q[rd_idx];

  lsp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .fire     (in_fire),
    .mode     (in_mode),
    .position (in_position),
    .cap      (cap_r),
    .top_word (cell_q[0]),
    .sel_word (sel_word),
    .ctl      (ctl),
    .rd_idx   (rd_idx),
    .res      (res)
  );

  // output register plus skid register; skid only fills when out is stuck
  always_comb begin
    out_nxt        = out_r;
    skid_nxt       = skid_r;
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    if (skid_valid_r) begin
      if (out_take) begin
        out_nxt        = skid_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (in_fire) begin
      if (!out_valid_r || out_take) begin
        out_nxt       = res;
        out_valid_nxt = 1'b1;
      end else begin
        skid_nxt       = res;
        skid_valid_nxt = 1'b1;
      end
    end else if (out_take) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_data     = out_r.data;
  assign out_status   = out_r.status;
  assign out_is_empty = out_r.is_empty;
  assign out_is_full  = out_r.is_full;

  // skid holds a result only behind a waiting output
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid register full while output register empty");

  // a dropped push leaves the stack full
  a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.status == ST_OVERFLOW) |-> out_r.is_full)
    else $error("overflow reported on a stack that is not full");

  // underflow only happens on an empty stack
  a_udf_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.status == ST_UNDERFLOW) |-> out_r.is_empty)
    else $error("underflow reported on a stack that is not empty");

  // capacity is at least one, so empty and full never coincide
  a_not_both: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_r.is_empty && out_r.is_full))
    else $error("result flagged both empty and full");

endmodule

`default_nettype wire
